@@ src/assert_macros.svh @@
// Assertion macros used by the checker.
// Depends on nothing; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/flpw_pkg.sv @@
// Shared types, sizes and helpers for the four-level page walker.
// No dependencies; used by every module of the block but flpw_ram.
package flpw_pkg;

   localparam int TABLE_COUNT       = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int SLOT_W            = $clog2(ENTRIES_PER_TABLE);
   localparam int TBL_W             = $clog2(TABLE_COUNT);
   localparam int STORE_DEPTH       = TABLE_COUNT * ENTRIES_PER_TABLE;
   localparam int ADDR_W            = TBL_W + SLOT_W;
   localparam int ROOT_W            = 6;
   localparam int INDEX_W           = 15;
   localparam int ENTRY_W           = 64;
   localparam int VA_W              = 48;
   localparam int PA_W              = 52;
   localparam int FRAME_W           = 40;
   localparam int OFFSET_W          = 12;
   localparam int LEVEL_W           = 2;

   typedef enum logic {
      ACTION_WRITE     = 1'b0,
      ACTION_TRANSLATE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NOT_MAPPED   = 2'd1,
      STATUS_OUT_OF_STORE = 2'd2
   } status_type;

   // Decoded command passed from front to back through the queue
   typedef struct packed {
      logic                is_write;
      logic [ADDR_W-1:0]   addr;
      logic [ENTRY_W-1:0]  value;
      logic [VA_W-1:0]     va;
   } cmd_type;

   // Table slot of a virtual address for a walk level (0 root .. 3 leaf)
   function automatic logic [SLOT_W-1:0] va_slot(input logic [VA_W-1:0] va,
                                                 input logic [LEVEL_W-1:0] level);
      logic [SLOT_W-1:0] slot;
      case (level)
         2'd0:    slot = va[47:39];
         2'd1:    slot = va[38:30];
         2'd2:    slot = va[29:21];
         default: slot = va[20:12];
      endcase
      return slot;
   endfunction

endpackage

@@ src/flpw_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module flpw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write through the port, register the read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

@@ src/flpw_front.sv @@
// Front end: accepts request transactions, classifies them, queues commands.
// Depends on flpw_pkg.
module flpw_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clearing,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [127:0]                  req_tdata,
   input  logic                          req_tuser,
   output logic                          head_valid,
   output flpw_pkg::cmd_type             head_cmd,
   input  logic                          head_pop
);

   flpw_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   logic [flpw_pkg::INDEX_W-1:0] entry_index;
   logic                         in_range;
   logic                         accept;
   logic                         push;
   flpw_pkg::cmd_type            cmd;

   // Hold off requests during the store clearing pass or when the queue is full
   assign req_tready = !clearing && (count_ff != 2'd2);
   assign accept     = req_tvalid && req_tready;

   // Classify: drop writes that fall beyond the store
   assign entry_index = req_tdata[14:0];
   assign in_range    = 32'(entry_index) < flpw_pkg::STORE_DEPTH;

   always_comb begin
      cmd.is_write = (flpw_pkg::action_type'(req_tuser) == flpw_pkg::ACTION_WRITE);
      cmd.addr     = flpw_pkg::ADDR_W'(entry_index);
      cmd.value    = req_tdata[78:15];
      cmd.va       = req_tdata[126:79];
   end

   assign push = accept && (!cmd.is_write || in_range);

   // Advance queue pointers and count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue payload needs no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

endmodule

@@ src/flpw_back.sv @@
// Back end: clears the table store, applies writes, walks translations.
// Depends on flpw_pkg and flpw_ram.
module flpw_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [flpw_pkg::ROOT_W-1:0]     root_table,
   output logic                            clearing,
   input  logic                            head_valid,
   input  flpw_pkg::cmd_type               head_cmd,
   output logic                            head_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [flpw_pkg::PA_W-1:0]       rsp_pa,
   output flpw_pkg::status_type            rsp_status,
   output logic [flpw_pkg::LEVEL_W-1:0]    rsp_level,
   output logic                            rsp_present,
   output logic                            rsp_writable
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK
   } state_type;

   localparam logic [flpw_pkg::ADDR_W-1:0] LAST_ADDR =
      flpw_pkg::ADDR_W'(flpw_pkg::STORE_DEPTH - 1);

   state_type                          state_ff, state_in;
   logic [flpw_pkg::ADDR_W-1:0]        clr_ff, clr_in;
   logic [flpw_pkg::LEVEL_W-1:0]       level_ff, level_in;
   logic [flpw_pkg::VA_W-1:0]          va_ff, va_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [flpw_pkg::PA_W-1:0]          pa_ff, pa_in;
   flpw_pkg::status_type               status_ff, status_in;
   logic [flpw_pkg::LEVEL_W-1:0]       stop_ff, stop_in;
   logic                               present_ff, present_in;
   logic                               writable_ff, writable_in;

   logic                               ram_we;
   logic [flpw_pkg::ADDR_W-1:0]        ram_addr;
   logic [flpw_pkg::ENTRY_W-1:0]       ram_wdata;
   logic [flpw_pkg::ENTRY_W-1:0]       ram_rdata;

   logic [flpw_pkg::FRAME_W-1:0]       frame;
   logic                               root_ok;
   logic                               frame_ok;
   logic [flpw_pkg::LEVEL_W-1:0]       next_level;

   flpw_ram #(
      .WIDTH (flpw_pkg::ENTRY_W),
      .DEPTH (flpw_pkg::STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Decode the entry read in the previous cycle
   assign frame      = ram_rdata[51:12];
   assign frame_ok   = frame < flpw_pkg::FRAME_W'(flpw_pkg::TABLE_COUNT);
   assign root_ok    = 32'(root_table) < flpw_pkg::TABLE_COUNT;
   assign next_level = level_ff + 2'd1;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      level_in     = level_ff;
      va_in        = va_ff;
      rsp_valid_in = rsp_valid_ff;
      pa_in        = pa_ff;
      status_in    = status_ff;
      stop_in      = stop_ff;
      present_in   = present_ff;
      writable_in  = writable_ff;
      ram_we       = 1'b0;
      ram_addr     = clr_ff;
      ram_wdata    = '0;
      head_pop     = 1'b0;

      // Drop the result once the consumer takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // Zero one store entry per cycle after reset
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end

         // Take the queue head: write at once, or start a walk at the root
         ST_IDLE: begin
            if (head_valid && head_cmd.is_write) begin
               head_pop  = 1'b1;
               ram_we    = 1'b1;
               ram_addr  = head_cmd.addr;
               ram_wdata = head_cmd.value;
            end else if (head_valid && !rsp_valid_ff) begin
               head_pop = 1'b1;
               va_in    = head_cmd.va;
               level_in = 2'd0;
               ram_addr = {flpw_pkg::TBL_W'(root_table),
                           flpw_pkg::va_slot(head_cmd.va, 2'd0)};
               if (root_ok) begin
                  state_in = ST_WALK;
               end else begin
                  rsp_valid_in = 1'b1;
                  pa_in        = '0;
                  status_in    = flpw_pkg::STATUS_OUT_OF_STORE;
                  stop_in      = 2'd0;
                  present_in   = 1'b0;
                  writable_in  = 1'b0;
               end
            end
         end

         // One level per cycle: check the entry, then read the next table
         ST_WALK: begin
            ram_addr = {frame[flpw_pkg::TBL_W-1:0], flpw_pkg::va_slot(va_ff, next_level)};
            if (level_ff == 2'd3) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               pa_in        = {frame, va_ff[flpw_pkg::OFFSET_W-1:0]};
               status_in    = flpw_pkg::STATUS_OK;
               stop_in      = 2'd3;
               present_in   = ram_rdata[0];
               writable_in  = ram_rdata[1];
            end else if (ram_rdata == '0) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               pa_in        = '0;
               status_in    = flpw_pkg::STATUS_NOT_MAPPED;
               stop_in      = level_ff;
               present_in   = 1'b0;
               writable_in  = 1'b0;
            end else if (!frame_ok) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               pa_in        = '0;
               status_in    = flpw_pkg::STATUS_OUT_OF_STORE;
               stop_in      = next_level;
               present_in   = 1'b0;
               writable_in  = 1'b0;
            end else begin
               level_in = next_level;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      level_ff    <= level_in;
      va_ff       <= va_in;
      pa_ff       <= pa_in;
      status_ff   <= status_in;
      stop_ff     <= stop_in;
      present_ff  <= present_in;
      writable_ff <= writable_in;
   end

   assign clearing     = (state_ff == ST_CLEAR);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pa       = pa_ff;
   assign rsp_status   = status_ff;
   assign rsp_level    = stop_ff;
   assign rsp_present  = present_ff;
   assign rsp_writable = writable_ff;

endmodule

@@ src/four_level_page_walk.sv @@
// Four-level page walker. A write updates one table entry as it is taken from the queue
// head; a translation goes from queue head to result register through the root,
// second, third and leaf reads, dependent through the single port of the table store.
// Translations do not overlap: a walk starts only once the last result left.
// After reset a clearing pass zeroes all 32768 store entries (TABLE_COUNT * 512);
// requests wait for it, then a two-entry queue takes requests while a walk runs.
module four_level_page_walk (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [14:0] entry_index, [78:15] entry_value, [126:79] lookup_va, [127] zero
   input  logic [127:0]                   req_tdata,
   // [0] action
   input  logic                           req_tuser,
   // Result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [51:0] physical_address, [53:52] stop_level, [54] leaf_present, [55] leaf_writable
   output logic [55:0]                    rsp_tdata,
   // [1:0] status
   output logic [1:0]                     rsp_tuser,
   // Configuration write: root_table
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [flpw_pkg::ROOT_W-1:0]    csr_data
);

   logic [flpw_pkg::ROOT_W-1:0]    root_ff;
   logic                           clearing;
   logic                           head_valid;
   flpw_pkg::cmd_type              head_cmd;
   logic                           head_pop;
   logic [flpw_pkg::PA_W-1:0]      rsp_pa;
   flpw_pkg::status_type           rsp_status;
   logic [flpw_pkg::LEVEL_W-1:0]   rsp_level;
   logic                           rsp_present;
   logic                           rsp_writable;

   // Hold the root table frame
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         root_ff <= csr_data;
      end
   end

   flpw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop)
   );

   flpw_back u_back (
      .clock        (clock),
      .reset        (reset),
      .root_table   (root_ff),
      .clearing     (clearing),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .head_pop     (head_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_pa       (rsp_pa),
      .rsp_status   (rsp_status),
      .rsp_level    (rsp_level),
      .rsp_present  (rsp_present),
      .rsp_writable (rsp_writable)
   );

   // Pack the result transaction
   assign rsp_tdata = {rsp_writable, rsp_present, rsp_level, rsp_pa};
   assign rsp_tuser = rsp_status;

endmodule

@@ src/flpw_checker.sv @@
// Port-level checks for the page walker, bound to the top level.
// Depends on flpw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module flpw_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [55:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // A stalled result holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // A failed walk reports no address and no leaf bits
   `ASSERT_IMPLIES(a_fail_zero, clock, reset, rsp_tvalid && rsp_tuser != flpw_pkg::STATUS_OK, rsp_tdata[51:0] == '0 && rsp_tdata[55:54] == 2'b00, "failed walk carries data")

   // A translated address always comes from the leaf level
   `ASSERT_IMPLIES(a_ok_leaf, clock, reset, rsp_tvalid && rsp_tuser == flpw_pkg::STATUS_OK, rsp_tdata[53:52] == 2'd3, "translation stopped above the leaf")

   // The leaf entry is never tested for zero
   `ASSERT_IMPLIES(a_unmapped_upper, clock, reset, rsp_tvalid && rsp_tuser == flpw_pkg::STATUS_NOT_MAPPED, rsp_tdata[53:52] != 2'd3, "not-mapped status at the leaf")

   // Requests are held off right after reset, for the store clearing pass
   `ASSERT_NEXT(a_clear_blocks, clock, 1'b0, reset, !req_tready, "request taken right after reset")

endmodule

bind four_level_page_walk flpw_checker u_flpw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
